@@ rtl/bsmm_pkg.sv @@
// Shared types and constants for the bounded set min/max gap tracker.
// No dependencies; every other file uses this package by scoped names.
`timescale 1ns / 1ps

package bsmm_pkg;

	localparam int STORE_DEPTH_DEF = 1024;
	localparam int CNT_W           = 11;
	localparam int VAL_W           = 32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic             status;
		logic [CNT_W-1:0] stored_count;
		logic             spans_valid;
		logic [VAL_W-1:0] shortest_span;
		logic [VAL_W-1:0] longest_span;
	} result_t;

endpackage

@@ rtl/bsmm_in_if.sv @@
// Input channel: valid/ready transfer of one signed value.
// Depends on bsmm_pkg.
`timescale 1ns / 1ps

interface bsmm_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [bsmm_pkg::VAL_W-1:0]  new_value;

	modport source (output valid, output new_value, input ready);
	modport sink   (input valid, input new_value, output ready);
endinterface

@@ rtl/bsmm_out_if.sv @@
// Result channel: valid/ready transfer of one status and span report.
// Depends on bsmm_pkg.
`timescale 1ns / 1ps

interface bsmm_out_if;
	logic                        valid;
	logic                        ready;
	logic                        status;
	logic [bsmm_pkg::CNT_W-1:0]  stored_count;
	logic                        spans_valid;
	logic [bsmm_pkg::VAL_W-1:0]  shortest_span;
	logic [bsmm_pkg::VAL_W-1:0]  longest_span;

	modport source (output valid, output status, output stored_count, output spans_valid,
		output shortest_span, output longest_span, input ready);
	modport sink   (input valid, input status, input stored_count, input spans_valid,
		input shortest_span, input longest_span, output ready);
endinterface

@@ rtl/bounded_set_min_max_gap_tracker.sv @@
// A value accepted with values already stored is compared with each by a scan that reads
// one store entry a cycle, then committed; a rejected or first value skips the scan.
// No new value is taken until the result of the last one has gone to the output register.
// A finished result waits in the output register while the next value is taken.
// Reset (arst_n low, asynchronous): count, spans and limit cleared, min gap all ones;
// the store itself is not cleared, entries are read only after they are written.
`timescale 1ns / 1ps

module bounded_set_min_max_gap_tracker #(
	parameter int STORE_DEPTH = bsmm_pkg::STORE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bsmm_pkg::CNT_W-1:0] cfg_wdata,
	bsmm_in_if.sink                    in_item,
	bsmm_out_if.source                 result
);

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	bsmm_pkg::result_t          res;
	bsmm_pkg::result_t          out_q;
	logic                       out_valid_q;
	logic                       res_valid;
	logic                       res_take;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [bsmm_pkg::VAL_W-1:0] mem_wdata;
	logic                       mem_re;
	logic [AW-1:0]              mem_raddr;
	logic [bsmm_pkg::VAL_W-1:0] mem_rdata;

	bsmm_core #(
		.STORE_DEPTH (STORE_DEPTH),
		.AW          (AW)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_item.valid),
		.in_ready  (in_item.ready),
		.in_value  (in_item.new_value),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	bsmm_store #(
		.DEPTH (STORE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register loads when empty or emptying in the same cycle
	assign res_take = res_valid && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.status        = out_q.status;
	assign result.stored_count  = out_q.stored_count;
	assign result.spans_valid   = out_q.spans_valid;
	assign result.shortest_span = out_q.shortest_span;
	assign result.longest_span  = out_q.longest_span;

endmodule

@@ rtl/bsmm_store.sv @@
// Value store: single-clock RAM, one write and one read port, registered read.
// Depends on bsmm_pkg for the data width.
`timescale 1ns / 1ps

module bsmm_store #(
	parameter int DEPTH = bsmm_pkg::STORE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [bsmm_pkg::VAL_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [bsmm_pkg::VAL_W-1:0] rdata
);

	logic [bsmm_pkg::VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/bsmm_core.sv @@
// Sequencer and span datapath: scans the store against an admitted value, then commits it.
// Depends on bsmm_pkg and drives the ports of bsmm_store.
`timescale 1ns / 1ps

module bsmm_core #(
	parameter int STORE_DEPTH = bsmm_pkg::STORE_DEPTH_DEF,
	parameter int AW          = $clog2(STORE_DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bsmm_pkg::CNT_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [bsmm_pkg::VAL_W-1:0] in_value,
	output logic                       res_valid,
	input  logic                       res_take,
	output bsmm_pkg::result_t          res,
	output logic                       mem_we,
	output logic [AW-1:0]              mem_waddr,
	output logic [bsmm_pkg::VAL_W-1:0] mem_wdata,
	output logic                       mem_re,
	output logic [AW-1:0]              mem_raddr,
	input  logic [bsmm_pkg::VAL_W-1:0] mem_rdata
);

	localparam int CW = bsmm_pkg::CNT_W;
	localparam int VW = bsmm_pkg::VAL_W;

	bsmm_pkg::state_t state_q, state_d;

	logic [CW-1:0] limit_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic [VW-1:0] v_q;
	logic          status_q;
	logic [VW-1:0] smallest_q;
	logic [VW-1:0] largest_q;
	logic [VW-1:0] min_gap_q;
	logic          rvalid_s1;
	logic          rvalid_s2;
	logic [VW-1:0] gap_s2;

	logic          in_fire;
	logic          room;
	logic          last_rd;
	logic          pipe_empty;
	logic          commit;
	logic [31:0]   cnt32;
	logic [31:0]   rd32;
	logic [VW-1:0] gap_s1;
	logic          spans_ok;

	assign cnt32      = 32'(count_q);
	assign rd32       = 32'(rd_idx_q);
	// effective limit is the smaller of the register and the store depth
	assign room       = (cnt32 + 32'd1 <= 32'(limit_q)) && (cnt32 < 32'(STORE_DEPTH));
	assign last_rd    = (rd_idx_q == CW'(count_q - CW'(1)));
	assign pipe_empty = !rvalid_s1 && !rvalid_s2;
	assign in_fire    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsmm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_re    = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			bsmm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!room) begin
						state_d = bsmm_pkg::ST_FINISH;
					end else if (count_q == '0) begin
						state_d = bsmm_pkg::ST_DRAIN;
					end else begin
						state_d = bsmm_pkg::ST_SCAN;
					end
				end
			end
			bsmm_pkg::ST_SCAN: begin
				mem_re = 1'b1;
				if (last_rd) begin
					state_d = bsmm_pkg::ST_DRAIN;
				end
			end
			bsmm_pkg::ST_DRAIN: begin
				// commit only once the last gap has reached min_gap_q
				if (pipe_empty) begin
					commit  = 1'b1;
					state_d = bsmm_pkg::ST_FINISH;
				end
			end
			bsmm_pkg::ST_FINISH: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = bsmm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bsmm_pkg::ST_IDLE;
			end
		endcase
	end

	assign mem_raddr = rd32[AW-1:0];
	assign mem_we    = commit;
	assign mem_waddr = cnt32[AW-1:0];
	assign mem_wdata = v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			v_q      <= in_value;
			status_q <= !room;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rvalid_s1 <= 1'b0;
			rvalid_s2 <= 1'b0;
		end else begin
			rvalid_s1 <= mem_re;
			rvalid_s2 <= rvalid_s1;
			if (in_fire) begin
				rd_idx_q <= '0;
			end else if (mem_re) begin
				rd_idx_q <= CW'(rd_idx_q + CW'(1));
			end
		end
	end

	assign gap_s1 = ($signed(v_q) < $signed(mem_rdata)) ? (mem_rdata - v_q) : (v_q - mem_rdata);

	always_ff @(posedge clk) begin
		if (rvalid_s1) begin
			gap_s2 <= gap_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			smallest_q <= '0;
			largest_q  <= '0;
			min_gap_q  <= '1;
		end else begin
			if (rvalid_s2 && (gap_s2 < min_gap_q)) begin
				min_gap_q <= gap_s2;
			end
			if (commit) begin
				count_q <= CW'(count_q + CW'(1));
				if (count_q == '0) begin
					smallest_q <= v_q;
					largest_q  <= v_q;
				end else begin
					if ($signed(v_q) < $signed(smallest_q)) begin
						smallest_q <= v_q;
					end
					if ($signed(largest_q) < $signed(v_q)) begin
						largest_q <= v_q;
					end
				end
			end
		end
	end

	assign spans_ok          = (count_q >= CW'(2));
	assign res.status        = status_q;
	assign res.stored_count  = count_q;
	assign res.spans_valid   = spans_ok;
	assign res.shortest_span = spans_ok ? min_gap_q : '0;
	assign res.longest_span  = spans_ok ? (largest_q - smallest_q) : '0;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt32 <= 32'(STORE_DEPTH))
		else $error("stored count above store depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (count_q == $past(count_q) || count_q == CW'($past(count_q) + CW'(1))))
		else $error("stored count moved by more than one");

	a_write_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (pipe_empty && !mem_re))
		else $error("store written while the scan is in flight");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (rd_idx_q < count_q))
		else $error("read of an entry not yet written");

	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !room) |=> (state_q == bsmm_pkg::ST_FINISH && $stable(count_q)))
		else $error("rejected value changed the store");
`endif

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for bounded_set_min_max_gap_tracker: burst-driven value stream,
// stalling result sink, in-bench predictor of count, status and spans.
// Depends on bsmm_pkg, bsmm_in_if, bsmm_out_if and the tracker RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int STORE_DEPTH = bsmm_pkg::STORE_DEPTH_DEF;
	localparam int CNT_W       = bsmm_pkg::CNT_W;
	localparam int VAL_W       = bsmm_pkg::VAL_W;
	// worst case is far below this: ~600 values, each scanning at most the values held
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int LONG_HOLD   = 300;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	typedef enum int {RX_FREE, RX_CHOPPY, RX_SLUGGISH} rx_mode_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	bsmm_in_if  in_if ();
	bsmm_out_if result_if ();

	bounded_set_min_max_gap_tracker #(
		.STORE_DEPTH(STORE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_item  (in_if),
		.result   (result_if)
	);

	// predictor state
	logic signed [VAL_W-1:0] held_values [STORE_DEPTH];
	int unsigned             held;
	logic signed [VAL_W-1:0] low_mark;
	logic signed [VAL_W-1:0] high_mark;
	logic [VAL_W-1:0]        closest_gap;
	logic [CNT_W-1:0]        capacity;

	logic signed [VAL_W-1:0] values_to_offer [$];
	bsmm_pkg::result_t       pending_reports [$];
	bsmm_pkg::result_t       want;
	int unsigned             values_queued;
	int unsigned             reports_seen;
	int unsigned             mismatches;
	int unsigned             cycle_count;

	int       burst_left;
	int       gap_left;
	int       hold_left;
	bit       hold_done;
	int       mode_left;
	rx_mode_t rx_mode;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Offer one value to the store and work out the report it must produce.
	function automatic bsmm_pkg::result_t admit_value(input logic signed [VAL_W-1:0] v);
		bsmm_pkg::result_t r;
		int unsigned       room;
		logic [VAL_W-1:0]  d;
		room = (capacity > STORE_DEPTH) ? STORE_DEPTH : capacity;
		r = '0;
		if (held + 1 > room || held >= STORE_DEPTH) begin
			r.status = 1'b1;
		end else begin
			for (int i = 0; i < held; i++) begin
				d = (v < held_values[i]) ? held_values[i] - v : v - held_values[i];
				if (d < closest_gap)
					closest_gap = d;
			end
			if (held == 0) begin
				low_mark  = v;
				high_mark = v;
			end else begin
				if (v < low_mark)
					low_mark = v;
				if (v > high_mark)
					high_mark = v;
			end
			held_values[held] = v;
			held++;
		end
		r.stored_count = CNT_W'(held);
		if (held >= 2) begin
			r.spans_valid   = 1'b1;
			r.shortest_span = closest_gap;
			r.longest_span  = high_mark - low_mark;
		end
		return r;
	endfunction

	// Only wide random values while the store is small, so the min gap shrinks slowly;
	// later on, also near-duplicates, extremes and a narrow band around zero.
	function automatic logic signed [VAL_W-1:0] rand_value();
		logic signed [VAL_W-1:0] v;
		int unsigned             pick;
		pick = $urandom_range(0, 99);
		if (held < 48 || pick < 45) begin
			v = $urandom;
		end else if (pick < 60) begin
			case ($urandom_range(0, 5))
				0: v = VAL_MIN;
				1: v = VAL_MAX;
				2: v = VAL_MIN + 1;
				3: v = VAL_MAX - 1;
				4: v = '0;
				default: v = '1;
			endcase
		end else if (pick < 80) begin
			v = held_values[$urandom_range(0, held - 1)] + ($urandom_range(0, 4) - 2);
		end else begin
			v = $urandom_range(0, 4000) - 2000;
		end
		return v;
	endfunction

	task automatic check_field(input string field, input logic [VAL_W-1:0] expected_val,
		input logic [VAL_W-1:0] actual_val);
		if (expected_val !== actual_val) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field,
				expected_val, actual_val);
			mismatches++;
		end
	endtask

	task automatic offer(input logic signed [VAL_W-1:0] v);
		values_to_offer = {values_to_offer, v};
		values_queued++;
	endtask

	// every value yields a report, so the block is idle once all reports are in
	task automatic settle();
		do
			@(posedge clk);
		while (reports_seen != values_queued);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CNT_W-1:0] lim);
		settle();
		cfg_wdata <= lim;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		capacity = lim;
	endtask

	// sender: bursts of random length with random gaps
	always @(posedge clk) begin
		if (in_if.valid && in_if.ready)
			pending_reports = {pending_reports, admit_value(in_if.new_value)};
		if (in_if.valid && !in_if.ready) begin
			// transfer pending, hold value
		end else if (gap_left != 0) begin
			in_if.valid <= 1'b0;
			gap_left--;
		end else if (values_to_offer.size() != 0) begin
			in_if.valid     <= 1'b1;
			in_if.new_value <= values_to_offer.pop_front();
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 20);
				gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0;
			end else begin
				burst_left--;
			end
		end else begin
			in_if.valid <= 1'b0;
		end
	end

	// receiver: changing stall pattern, plus one long hold while values keep coming
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_if.ready <= 1'b0;
			hold_left--;
		end else if (!hold_done && reports_seen >= 30 && values_to_offer.size() > 4) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
			result_if.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(16, 200);
			end else begin
				mode_left--;
			end
			case (rx_mode)
				RX_FREE:   result_if.ready <= 1'b1;
				RX_CHOPPY: result_if.ready <= ($urandom_range(0, 1) == 1);
				default:   result_if.ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (result_if.valid && result_if.ready) begin
			reports_seen++;
			if (pending_reports.size() == 0) begin
				$display("%0t: report with none expected, actual count %0d status %0b",
					$time, result_if.stored_count, result_if.status);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				check_field("status", VAL_W'(want.status), VAL_W'(result_if.status));
				check_field("stored_count", VAL_W'(want.stored_count),
					VAL_W'(result_if.stored_count));
				check_field("spans_valid", VAL_W'(want.spans_valid),
					VAL_W'(result_if.spans_valid));
				check_field("shortest_span", want.shortest_span, result_if.shortest_span);
				check_field("longest_span", want.longest_span, result_if.longest_span);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		int unsigned random_sent;
		int unsigned n;
		int unsigned kind;
		logic [CNT_W-1:0] lim;

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		in_if.valid     = 1'b0;
		in_if.new_value = '0;
		result_if.ready = 1'b0;
		held            = 0;
		low_mark        = '0;
		high_mark       = '0;
		closest_gap     = '1;
		capacity        = '0;
		values_queued   = 0;
		reports_seen    = 0;
		mismatches      = 0;
		cycle_count     = 0;
		burst_left      = 0;
		gap_left        = 0;
		hold_left       = 0;
		hold_done       = 1'b0;
		mode_left       = 0;
		rx_mode         = RX_FREE;
		random_sent     = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// limit still at reset value: everything rejected
		offer(VAL_MIN);
		offer(VAL_MAX);
		offer('0);
		set_capacity(11'd1);
		offer(VAL_MIN);
		offer(VAL_MAX);            // store full
		set_capacity(11'd2);
		offer(VAL_MAX);            // both spans span the full range
		offer(-32'sd5);
		set_capacity(11'd8);
		offer(32'sh0000_0000);
		offer(32'sh4000_0000);
		offer(32'shC000_0000);
		offer(32'sh6000_0000);
		offer(32'sh2000_0000);
		offer(32'sh1234_5678);
		offer(32'sh0F0F_0F0F);     // one past the limit
		// limit below the count: stored values stay, nothing more admitted
		set_capacity(11'd4);
		offer(32'sd3);
		offer(32'sd123);

		while (random_sent < 550) begin
			kind = $urandom_range(0, 9);
			if (kind < 2)
				lim = CNT_W'($urandom_range(0, held));
			else if (kind == 2)
				lim = $urandom_range(0, 1) ? 11'd2047 : 11'd1024;
			else
				lim = CNT_W'(held + $urandom_range(1, 24));
			set_capacity(lim);
			n = $urandom_range(4, 30);
			repeat (n) offer(rand_value());
			random_sent += n;
		end

		// limit above store depth: the depth is the effective limit
		set_capacity(11'd2047);
		repeat (2) offer(rand_value());
		set_capacity(11'd0);
		repeat (2) offer(rand_value());

		settle();
		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/bsmm_pkg.sv
rtl/bsmm_in_if.sv
rtl/bsmm_out_if.sv
rtl/bsmm_store.sv
rtl/bsmm_core.sv
rtl/bounded_set_min_max_gap_tracker.sv
bench/testbench.sv
